// File: rtl/core/sha1_pkg.sv
// Shared constants, command struct, state codes and round helpers for the SHA-1 unit.
// Used by sha1_ctrl, sha1_sched, sha1_round and sha1_hash_unit; depends on nothing.
package sha1_pkg;

    localparam int WORD_W    = 32;
    localparam int POS_W     = 4;
    localparam int ROUND_W   = 7;
    localparam int DIGEST_IW = 3;
    localparam int COUNT_W   = 64;

    localparam logic [POS_W-1:0]     BLOCK_LAST  = 4'd15;
    localparam logic [POS_W-1:0]     LEN_HI_POS  = 4'd14;
    localparam logic [ROUND_W-1:0]   LAST_ROUND  = 7'd79;
    localparam logic [DIGEST_IW-1:0] LAST_DIGEST = 3'd4;
    localparam logic [2:0]           FULL_BYTES  = 3'd4;

    localparam logic [WORD_W-1:0] IV0 = 32'h6745_2301;
    localparam logic [WORD_W-1:0] IV1 = 32'hefcd_ab89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98ba_dcfe;
    localparam logic [WORD_W-1:0] IV3 = 32'h1032_5476;
    localparam logic [WORD_W-1:0] IV4 = 32'hc3d2_e1f0;

    localparam logic [WORD_W-1:0] K0 = 32'h5a82_7999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ed9_eba1;
    localparam logic [WORD_W-1:0] K2 = 32'h8f1b_bcdc;
    localparam logic [WORD_W-1:0] K3 = 32'hca62_c1d6;

    localparam logic [WORD_W-1:0] PAD_MARK = 32'h8000_0000;

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } sha1_state_t;

    typedef struct packed {
        logic                 push;
        logic                 expand;
        logic                 init;
        logic                 step;
        logic                 add;
        logic                 load_iv;
        logic [ROUND_W-1:0]   round;
        logic [DIGEST_IW-1:0] out_sel;
    } sha1_cmd_t;

    // Final word: keep the valid high bytes and open the padding right after them.
    function automatic logic [WORD_W-1:0] last_word(input logic [WORD_W-1:0] word,
                                                    input logic [2:0] nbytes);
        logic [WORD_W-1:0] res;
        case (nbytes)
            3'd0:    res = PAD_MARK;
            3'd1:    res = {word[31:24], 8'h80, 16'h0000};
            3'd2:    res = {word[31:16], 8'h80, 8'h00};
            3'd3:    res = {word[31:8], 8'h80};
            default: res = word;
        endcase
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] c,
                                                  input logic [WORD_W-1:0] d,
                                                  input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] res;
        if (t < 7'd20)
            res = (b & c) | (~b & d);
        else if (t < 7'd40)
            res = b ^ c ^ d;
        else if (t < 7'd60)
            res = (b & c) | (b & d) | (c & d);
        else
            res = b ^ c ^ d;
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] res;
        if (t < 7'd20)
            res = K0;
        else if (t < 7'd40)
            res = K1;
        else if (t < 7'd60)
            res = K2;
        else
            res = K3;
        return res;
    endfunction

endpackage

// File: rtl/core/sha1_sched.sv
// Sixteen-word message schedule held as a shift line with fixed taps.
// Depends on sha1_pkg for the command struct and word width.
module sha1_sched (
    input  logic                       clk,
    input  sha1_pkg::sha1_cmd_t        cmd,
    input  logic [sha1_pkg::WORD_W-1:0] push_data,
    output logic [sha1_pkg::WORD_W-1:0] sched_word
);
    import sha1_pkg::*;

    logic [WORD_W-1:0] sched_reg [16];
    logic [WORD_W-1:0] expand_word;
    logic [WORD_W-1:0] shift_in;

    // The line always holds W[t] to W[t+15], so the next expanded word uses fixed taps.
    assign expand_word = {sched_reg[13][30:0] ^ sched_reg[8][30:0] ^
                          sched_reg[2][30:0] ^ sched_reg[0][30:0],
                          sched_reg[13][31] ^ sched_reg[8][31] ^
                          sched_reg[2][31] ^ sched_reg[0][31]};
    assign shift_in   = cmd.push ? push_data : expand_word;
    assign sched_word = sched_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.expand)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= shift_in;
        end
    end

endmodule

// File: rtl/core/sha1_round.sv
// Working registers, chaining words and the single SHA-1 round unit.
// Depends on sha1_pkg for constants, round helpers and the command struct.
module sha1_round (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sha1_pkg::sha1_cmd_t         cmd,
    input  logic [sha1_pkg::WORD_W-1:0] sched_word,
    output logic [sha1_pkg::WORD_W-1:0] digest_word
);
    import sha1_pkg::*;

    logic [WORD_W-1:0] work_reg  [5];
    logic [WORD_W-1:0] chain_reg [5];
    logic [WORD_W-1:0] temp_next;

    assign temp_next = {work_reg[0][26:0], work_reg[0][31:27]}
                     + round_f(work_reg[1], work_reg[2], work_reg[3], cmd.round)
                     + work_reg[4] + round_k(cmd.round) + sched_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            chain_reg[4] <= IV4;
            for (int i = 0; i < 5; i++)
            begin
                work_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.init)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    work_reg[i] <= chain_reg[i];
                end
            end
            else if (cmd.step)
            begin
                work_reg[0] <= temp_next;
                work_reg[1] <= work_reg[0];
                work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
                work_reg[3] <= work_reg[2];
                work_reg[4] <= work_reg[3];
            end

            if (cmd.load_iv)
            begin
                chain_reg[0] <= IV0;
                chain_reg[1] <= IV1;
                chain_reg[2] <= IV2;
                chain_reg[3] <= IV3;
                chain_reg[4] <= IV4;
            end
            else if (cmd.add)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        case (cmd.out_sel)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

endmodule

// File: rtl/core/sha1_ctrl.sv
// Sequencer: word intake, padding and length words, round count and digest readout.
// Depends on sha1_pkg for the state codes, command struct and padding helper.
module sha1_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        message_valid,
    input  logic [31:0]                 message_word,
    input  logic [2:0]                  valid_bytes,
    input  logic                        message_end,
    input  logic                        digest_stall,
    output logic                        message_stall,
    output logic                        digest_valid,
    output logic                        digest_last,
    output sha1_pkg::sha1_cmd_t         cmd,
    output logic [sha1_pkg::WORD_W-1:0] push_data
);
    import sha1_pkg::*;

    sha1_state_t          state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [COUNT_W-1:0]   bits_reg, bits_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [DIGEST_IW-1:0] out_reg, out_next;
    logic                 pad_reg, pad_next;
    logic                 mark_reg, mark_next;
    logic                 hi_reg, hi_next;
    logic                 done_reg, done_next;
    logic [2:0]           nbytes;

    assign nbytes        = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
    assign message_stall = (state_reg != S_LOAD);
    assign digest_valid  = (state_reg == S_OUT);
    assign digest_last   = (out_reg == LAST_DIGEST);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        bits_next  = bits_reg;
        round_next = round_reg;
        out_next   = out_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        hi_next    = hi_reg;
        done_next  = done_reg;
        cmd        = '0;
        push_data  = '0;
        cmd.round   = round_reg;
        cmd.out_sel = out_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (message_valid)
                begin
                    cmd.push = 1'b1;
                    if (message_end)
                    begin
                        bits_next  = bits_reg + {58'd0, nbytes, 3'b000};
                        push_data  = last_word(message_word, nbytes);
                        mark_next  = (nbytes == FULL_BYTES);
                        pad_next   = 1'b1;
                        state_next = S_PAD;
                    end
                    else
                    begin
                        bits_next = bits_reg + 64'd32;
                        push_data = message_word;
                    end
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == BLOCK_LAST)
                    begin
                        cmd.init   = 1'b1;
                        state_next = S_COMP;
                    end
                end
            end

            S_PAD:
            begin
                cmd.push = 1'b1;
                // A full final word still owes its marker word before any zeros.
                if (mark_reg)
                begin
                    push_data = PAD_MARK;
                    mark_next = 1'b0;
                end
                else if (hi_reg)
                begin
                    push_data = bits_reg[31:0];
                    done_next = 1'b1;
                end
                else if (pos_reg == LEN_HI_POS)
                begin
                    push_data = bits_reg[63:32];
                    hi_next   = 1'b1;
                end
                else
                begin
                    push_data = '0;
                end
                pos_next = pos_reg + 4'd1;
                if (pos_reg == BLOCK_LAST)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_COMP;
                end
            end

            S_COMP:
            begin
                cmd.step   = 1'b1;
                cmd.expand = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                cmd.add = 1'b1;
                if (done_reg)
                    state_next = S_OUT;
                else if (pad_reg)
                    state_next = S_PAD;
                else
                    state_next = S_LOAD;
            end

            S_OUT:
            begin
                if (!digest_stall)
                begin
                    out_next = out_reg + 3'd1;
                    if (out_reg == LAST_DIGEST)
                    begin
                        out_next    = '0;
                        cmd.load_iv = 1'b1;
                        bits_next   = '0;
                        pos_next    = '0;
                        pad_next    = 1'b0;
                        mark_next   = 1'b0;
                        hi_next     = 1'b0;
                        done_next   = 1'b0;
                        state_next  = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            pos_reg   <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            out_reg   <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            hi_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            bits_reg  <= bits_next;
            round_reg <= round_next;
            out_reg   <= out_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            hi_reg    <= hi_next;
            done_reg  <= done_next;
        end
    end

endmodule

// File: rtl/core/sha1_hash_unit.sv
// Top level of the streaming SHA-1 unit: sequencer, schedule line and round unit.
// Depends on sha1_pkg, sha1_ctrl, sha1_sched and sha1_round.
//
//   channel   direction  handshake                      payload
//   message   in         message_valid / message_stall  message_word, valid_bytes, message_end
//   digest    out        digest_valid / digest_stall    digest_word, digest_last
//
// Message words are taken while message_stall is low; the sixteenth word of a block starts
// a compression (one round per cycle in the shared round unit) followed by a step that
// folds the result into the chaining words. Padding and length words are pushed one per
// cycle after the final word, pausing while a filled block is compressed, then the five
// digest words are offered one per cycle as the consumer takes them.
// message_stall is high whenever the block is compressing, padding or reading out.
// Reset is asynchronous and loads the initial chaining values; no clearing pass.
module sha1_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        message_valid,
    output logic        message_stall,
    input  logic [31:0] message_word,
    input  logic [2:0]  valid_bytes,
    input  logic        message_end,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic        digest_last
);
    import sha1_pkg::*;

    sha1_cmd_t         cmd;
    logic [WORD_W-1:0] push_data;
    logic [WORD_W-1:0] sched_word;

    sha1_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .message_valid (message_valid),
        .message_word  (message_word),
        .valid_bytes   (valid_bytes),
        .message_end   (message_end),
        .digest_stall  (digest_stall),
        .message_stall (message_stall),
        .digest_valid  (digest_valid),
        .digest_last   (digest_last),
        .cmd           (cmd),
        .push_data     (push_data)
    );

    sha1_sched u_sched (
        .clk        (clk),
        .cmd        (cmd),
        .push_data  (push_data),
        .sched_word (sched_word)
    );

    sha1_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sched_word  (sched_word),
        .digest_word (digest_word)
    );

endmodule

// File: rtl/core/sha1_hash_unit_chk.sv
// Port-level checker for sha1_hash_unit and the bind that attaches it.
// Depends only on the top level's ports.
module sha1_hash_unit_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        message_valid,
    input logic        message_stall,
    input logic [31:0] message_word,
    input logic [2:0]  valid_bytes,
    input logic        message_end,
    input logic        digest_valid,
    input logic        digest_stall,
    input logic [31:0] digest_word,
    input logic        digest_last
);

    // A held digest word must not change while the consumer stalls.
    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest_word)
                                         && $stable(digest_last))
        else $error("digest word changed while stalled");

    // No message word is taken while the digest is being read out.
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> message_stall)
        else $error("message intake open during digest readout");

    // The final message word always leads into busy work (padding or compression) first.
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        message_valid && !message_stall && message_end |=> message_stall && !digest_valid)
        else $error("block not busy after final message word");

    // Readout runs without gaps until the last digest word, then stops.
    a_out_seq: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall |=> (digest_valid != $past(digest_last)))
        else $error("digest readout sequence broken");

endmodule

bind sha1_hash_unit sha1_hash_unit_chk u_chk (.*);
